// File: hdl/prq_pkg.sv
// Shared types and constants of the priority ring queue.
`default_nettype none
package prq_pkg;

	localparam int DEPTH         = 16;
	localparam int EVENT_BITS    = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int ADDR_BITS     = $clog2(DEPTH);
	localparam int COUNT_BITS    = $clog2(DEPTH + 1);
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_OVERWRITE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY  = 1'd1;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Read offset source for the store's read port
	typedef enum logic [1:0] {
		OFF_ZERO   = 2'd0,
		OFF_K_NEXT = 2'd1,
		OFF_J_M1   = 2'd2,
		OFF_J_M2   = 2'd3
	} rd_off_t;

	typedef struct packed {
		op_t                      op;
		logic [EVENT_BITS-1:0]    event_code;
		logic [PRIORITY_BITS-1:0] event_priority;
	} req_item_t;

	typedef struct packed {
		logic                     accepted;
		logic [EVENT_BITS-1:0]    popped_event;
		logic [PRIORITY_BITS-1:0] popped_priority;
		logic [COUNT_BITS-1:0]    fill_count;
		logic                     is_empty;
		logic                     is_full;
	} rsp_item_t;

	typedef struct packed {
		logic [EVENT_BITS-1:0]    ev;
		logic [PRIORITY_BITS-1:0] pr;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		rd_off_t rd_off;
		logic    k_clr;
		logic    k_inc;
		logic    j_load;
		logic    j_dec;
		logic    shift_wr;
		logic    put;
		logic    reject;
		logic    do_append;
		logic    do_pop;
		logic    do_clear;
	} prq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic scan_stop;
		logic reject_cond;
		logic need_shift;
		logic shift_more;
		logic slot_free;
	} prq_stat_t;

endpackage
`default_nettype wire

// File: hdl/prq_datapath.sv
// Datapath of the priority ring queue: entry store, indexes, scan and shift counters, result.
`default_nettype none
module prq_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prq_pkg::req_item_t req_item,
	input  wire prq_pkg::prq_cmd_t  cmd,
	output prq_pkg::prq_stat_t      stat,
	input  wire logic              cfg_we,
	input  wire logic [prq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [prq_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output prq_pkg::rsp_item_t      rsp_item
);
	import prq_pkg::*;

	// Ring offset added to a base index, wrapped at the capacity in use
	function automatic logic [ADDR_BITS-1:0] phys(input logic [ADDR_BITS-1:0] base,
			input logic [COUNT_BITS-1:0] off, input logic [COUNT_BITS-1:0] cap);
		logic [COUNT_BITS:0] s;
		s = (COUNT_BITS+1)'(base) + (COUNT_BITS+1)'(off);
		if (s >= (COUNT_BITS+1)'(cap)) begin
			s = s - (COUNT_BITS+1)'(cap);
		end
		return s[ADDR_BITS-1:0];
	endfunction

	function automatic logic [ADDR_BITS-1:0] inc_wrap(input logic [ADDR_BITS-1:0] base,
			input logic [COUNT_BITS-1:0] cap);
		logic [COUNT_BITS-1:0] s;
		s = COUNT_BITS'(base) + COUNT_BITS'(1);
		if (s >= cap) begin
			s = '0;
		end
		return s[ADDR_BITS-1:0];
	endfunction

	entry_t                mem [DEPTH];
	entry_t                rdata_q;
	req_item_t             item_q;
	logic [ADDR_BITS-1:0]  wr_q, rd_q;
	logic [COUNT_BITS-1:0] cnt_q, cap_q;
	logic                  ovw_q;
	logic [COUNT_BITS-1:0] k_q;
	logic [ADDR_BITS-1:0]  j_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  full;
	logic [COUNT_BITS-1:0] n_shift;
	logic [COUNT_BITS-1:0] j_m1;
	logic [COUNT_BITS-1:0] rd_off;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  waddr;
	entry_t                wdata;
	logic [ADDR_BITS-1:0]  wr_d, rd_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic                  res_load;
	logic                  res_acc;
	entry_t                res_pop;
	logic [COUNT_BITS-1:0] cap_wr;

	// Status toward the controller
	always_comb begin
		full    = cnt_q >= cap_q;
		n_shift = full ? cap_q - COUNT_BITS'(1) : cnt_q;
		j_m1    = COUNT_BITS'(j_q) - COUNT_BITS'(1);
		stat.op          = item_q.op;
		stat.scan_stop   = (k_q == cnt_q) || (rdata_q.pr < item_q.event_priority);
		stat.reject_cond = full && (k_q == cnt_q);
		stat.need_shift  = n_shift > k_q;
		stat.shift_more  = j_m1 > k_q;
		stat.slot_free   = !rsp_valid_q || !rsp_stall;
	end

	// Select the read address
	always_comb begin
		case (cmd.rd_off)
			OFF_ZERO:   rd_off = '0;
			OFF_K_NEXT: rd_off = k_q + COUNT_BITS'(1);
			OFF_J_M1:   rd_off = j_m1;
			default:    rd_off = COUNT_BITS'(j_q) - COUNT_BITS'(2);
		endcase
		rd_addr = phys(rd_q, rd_off, cap_q);
	end

	// Operation results, index updates and the write port
	always_comb begin
		mem_we   = 1'b0;
		waddr    = wr_q;
		wdata    = '{ev: item_q.event_code, pr: item_q.event_priority};
		wr_d     = wr_q;
		rd_d     = rd_q;
		cnt_d    = cnt_q;
		res_load = 1'b0;
		res_acc  = 1'b0;
		res_pop  = '0;
		if (cmd.do_append) begin
			res_load = 1'b1;
			if (!full || ovw_q) begin
				res_acc = 1'b1;
				mem_we  = 1'b1;
				wr_d    = inc_wrap(wr_q, cap_q);
				if (full) begin
					rd_d = inc_wrap(rd_q, cap_q);
				end else begin
					cnt_d = cnt_q + COUNT_BITS'(1);
				end
			end
		end
		if (cmd.do_pop) begin
			res_load = 1'b1;
			if (cnt_q != '0) begin
				res_acc = 1'b1;
				res_pop = rdata_q;
				rd_d    = inc_wrap(rd_q, cap_q);
				cnt_d   = cnt_q - COUNT_BITS'(1);
			end
		end
		if (cmd.do_clear) begin
			res_load = 1'b1;
			res_acc  = 1'b1;
			wr_d     = '0;
			rd_d     = '0;
			cnt_d    = '0;
		end
		if (cmd.shift_wr) begin
			mem_we = 1'b1;
			waddr  = phys(rd_q, COUNT_BITS'(j_q), cap_q);
			wdata  = rdata_q;
		end
		if (cmd.put) begin
			res_load = 1'b1;
			res_acc  = 1'b1;
			mem_we   = 1'b1;
			waddr    = phys(rd_q, k_q, cap_q);
			if (!full) begin
				wr_d  = inc_wrap(wr_q, cap_q);
				cnt_d = cnt_q + COUNT_BITS'(1);
			end
		end
		if (cmd.reject) begin
			res_load = 1'b1;
		end
	end

	// Clamp a capacity write into 1..DEPTH
	always_comb begin
		cap_wr = COUNT_BITS'(cfg_data);
		if (cap_wr == '0) begin
			cap_wr = COUNT_BITS'(1);
		end else if (cap_wr > COUNT_BITS'(DEPTH)) begin
			cap_wr = COUNT_BITS'(DEPTH);
		end
	end

	// Entry store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Indexes, counters, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			ovw_q       <= 1'b0;
			cap_q       <= COUNT_BITS'(DEPTH);
			k_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A capacity write empties the queue
			if (cfg_we && (cfg_index == CFG_CAPACITY)) begin
				cap_q <= cap_wr;
				wr_q  <= '0;
				rd_q  <= '0;
				cnt_q <= '0;
			end else begin
				wr_q  <= wr_d;
				rd_q  <= rd_d;
				cnt_q <= cnt_d;
			end
			if (cfg_we && (cfg_index == CFG_OVERWRITE)) begin
				ovw_q <= cfg_data[0];
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + COUNT_BITS'(1);
			end
			if (cmd.j_load) begin
				j_q <= n_shift[ADDR_BITS-1:0];
			end else if (cmd.j_dec) begin
				j_q <= j_q - ADDR_BITS'(1);
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_item;
		end
		if (res_load) begin
			rsp_q.accepted        <= res_acc;
			rsp_q.popped_event    <= res_pop.ev;
			rsp_q.popped_priority <= res_pop.pr;
			rsp_q.fill_count      <= cnt_d;
			rsp_q.is_empty        <= cnt_d == '0;
			rsp_q.is_full         <= (cnt_d >= cap_q) && !ovw_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule
`default_nettype wire

// File: hdl/prq_controller.sv
// Controller of the priority ring queue: sequences each operation over the datapath.
`default_nettype none
module prq_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire prq_pkg::prq_stat_t stat,
	output prq_pkg::prq_cmd_t       cmd
);
	import prq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_PRIME,
		S_SHIFT,
		S_PUT,
		S_REJECT
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_off    = OFF_ZERO;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					OP_INSERT: begin
						cmd.k_clr = 1'b1;
						state_d   = S_SCAN;
					end
					OP_APPEND: begin
						if (stat.slot_free) begin
							cmd.do_append = 1'b1;
							state_d       = S_IDLE;
						end
					end
					OP_POP: begin
						if (stat.slot_free) begin
							cmd.do_pop = 1'b1;
							state_d    = S_IDLE;
						end
					end
					default: begin
						if (stat.slot_free) begin
							cmd.do_clear = 1'b1;
							state_d      = S_IDLE;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (stat.scan_stop) begin
					if (stat.reject_cond) begin
						state_d = S_REJECT;
					end else if (stat.need_shift) begin
						cmd.j_load = 1'b1;
						state_d    = S_PRIME;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					cmd.k_inc  = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_K_NEXT;
				end
			end
			S_PRIME: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = OFF_J_M1;
				state_d    = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				cmd.j_dec    = 1'b1;
				if (stat.shift_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_J_M2;
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (stat.slot_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_REJECT: begin
				if (stat.slot_free) begin
					cmd.reject = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule
`default_nettype wire

// File: hdl/priority_ring_queue_unit.sv
// Top level of the priority ring queue.
//
// A circular queue of event and priority entries, 16 deep. The request channel
// (req_valid, req_stall, req_item) carries one operation per item: append, priority
// insert, pop or clear. Each item yields one result item on the response channel
// (rsp_valid, rsp_stall, rsp_item). The config channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) sets overwrite mode and the capacity in use; write it
// only while no operation is in flight. A capacity write empties the queue.
// Append, pop and clear: the item is registered and the head entry read, then the
// operation is done and its result registered. A priority insert scans the entries
// from the head for the first one of lower priority or the end, moves the entries
// from there up by one and puts the new entry in its place. The entry store, read at
// one address per cycle, sets the pace: one entry compared per cycle in the scan and
// one entry moved per cycle in the shift. A new request is taken only in idle.
// Reset: queue empty, overwrite off, capacity 16; store contents undefined.
// A stalled response holds in its register; the next item is taken and worked
// on, and its result waits until the register frees.
`default_nettype none
module priority_ring_queue_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire prq_pkg::req_item_t  req_item,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output prq_pkg::rsp_item_t       rsp_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [prq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [prq_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import prq_pkg::*;

	prq_cmd_t  cmd;
	prq_stat_t stat;

	// Config writes are taken at any time
	assign cfg_ready = 1'b1;

	prq_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	prq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule
`default_nettype wire

// File: hdl/prq_checker.sv
// Port-level checker of the priority ring queue and its bind to the top level.
`default_nettype none
module prq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire prq_pkg::rsp_item_t rsp_item
);
	import prq_pkg::*;

	// A stalled result item stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// Popped fields are zero unless the operation succeeded
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.accepted |->
			(rsp_item.popped_event == '0) && (rsp_item.popped_priority == '0))
		else $error("popped fields set on a rejected operation");

	// Empty flag agrees with the fill count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_item.is_empty == (rsp_item.fill_count == '0))
		else $error("empty flag disagrees with fill count");

	// Fill count never exceeds the store depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_item.fill_count <= COUNT_BITS'(DEPTH))
		else $error("fill count above depth");

	// A full queue holds at least one entry
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.is_full |-> !rsp_item.is_empty)
		else $error("full and empty at once");

endmodule

bind priority_ring_queue_unit prq_checker u_prq_checker (.*);
`default_nettype wire
